/* sv/swls_pkg.sv */
// Shared types and constants for the sliding window length statistics block.
// Used by the divider and the top level; no dependencies.
package swls_pkg;

    localparam int CNT_W = 32;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam int PCT_SCALE = 100;
    localparam int TENTHS_SCALE = 2000;
    localparam int RING_DEPTH = 16;
    localparam int LEN_MAX = 64;

    localparam logic REQ_RECORD = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV_ISSUE,
        ST_DIV_WAIT,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_WAVG,
        OP_WZPCT,
        OP_OAVG,
        OP_OZPCT,
        OP_BPCT
    } op_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* sv/sliding_window_length_stats_top.sv */
// Top level of the sliding window ack length statistics block.
// Depends on swls_pkg, swls_ram (ring and histogram) and swls_div.
//
//  Channel | Direction | Ports
//  --------+-----------+--------------------------------------------------
//  request | in        | s_valid, s_ready, s_req_type, s_ack_bits, ...
//  result  | out       | m_valid, m_ready, m_status, m_window_count, ...
//
// Each item makes five passes through the shared bit-serial divider.
// Reset is synchronous and active low; the histogram reads as zero after
// reset through per-bin valid flags, so no clearing pass is needed.
// A new request is taken while the previous result still waits in the
// output register; only the final load waits for that register to drain.
module sliding_window_length_stats_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [6:0]  s_ack_bits,
    input  logic [6:0]  s_ack_zeros,
    input  logic [6:0]  s_bin_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_status,
    output logic [4:0]  m_window_count,
    output logic [6:0]  m_window_avg_len,
    output logic [6:0]  m_window_zero_pct,
    output logic [6:0]  m_overall_avg_len,
    output logic [6:0]  m_overall_zero_pct,
    output logic [31:0] m_ack_total,
    output logic [31:0] m_bin_count,
    output logic [9:0]  m_bin_pct_tenths
);
    import swls_pkg::*;

    localparam int LEN_W  = $clog2(LEN_MAX + 1);
    localparam int HA_W   = $clog2(LEN_MAX + 1);
    localparam int RA_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int WSUM_W = $clog2(RING_DEPTH * LEN_MAX + 1);
    localparam int OSUM_W = CNT_W + LEN_W;
    localparam int NUM_W  = (OSUM_W + 7 > 43) ? OSUM_W + 7 : 43;
    localparam int DEN_W  = OSUM_W;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    logic              req_type_reg, req_type_next;
    logic [LEN_W-1:0]  bits_reg, bits_next;
    logic [LEN_W-1:0]  zeros_reg, zeros_next;
    logic [HA_W-1:0]   haddr_reg, haddr_next;
    logic              bad_reg, bad_next;
    logic [RA_W-1:0]   slot_reg, slot_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [WSUM_W-1:0] wbit_reg, wbit_next;
    logic [WSUM_W-1:0] wzero_reg, wzero_next;
    logic [OSUM_W-1:0] obit_reg, obit_next;
    logic [OSUM_W-1:0] ozero_reg, ozero_next;
    logic [CNT_W-1:0]  ack_reg, ack_next;
    logic [LEN_MAX:0]  hvalid_reg, hvalid_next;
    logic [CNT_W-1:0]  bcount_reg, bcount_next;
    logic              have_bin_reg, have_bin_next;
    logic [6:0]        wavg_reg, wavg_next;
    logic [6:0]        wzpct_reg, wzpct_next;
    logic [6:0]        oavg_reg, oavg_next;
    logic [6:0]        ozpct_reg, ozpct_next;
    logic [9:0]        bpct_reg, bpct_next;
    logic              m_valid_reg, m_valid_next;

    logic s_accept, load_out, div_start;
    logic in_bad;
    logic [HA_W-1:0] in_haddr;

    logic [2*LEN_W-1:0] ring_q;
    logic               ring_we;
    logic [CNT_W-1:0]   hist_q;
    logic [CNT_W-1:0]   hist_wdata;
    logic               hist_we;
    logic [CNT_W-1:0]   hist_val;
    logic [LEN_W-1:0]   old_bits, old_zeros;

    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic [NUM_W-1:0] div_quot;
    div_stat_t        div_stat;

    assign s_accept = s_valid && s_ready;
    assign old_bits  = ring_q[2*LEN_W-1:LEN_W];
    assign old_zeros = ring_q[LEN_W-1:0];
    assign hist_val  = hvalid_reg[haddr_reg] ? hist_q : '0;

    always_comb begin
        if (s_req_type == REQ_RECORD) begin
            in_bad = (s_ack_bits == 7'd0) || (32'(s_ack_bits) > LEN_MAX)
                     || (s_ack_zeros > s_ack_bits);
            in_haddr = HA_W'(s_ack_bits);
        end else begin
            in_bad   = 32'(s_bin_index) > LEN_MAX;
            in_haddr = HA_W'(s_bin_index);
        end
    end

    swls_ram #(.WIDTH(2 * LEN_W), .DEPTH(RING_DEPTH)) u_ring (
        .aclk  (aclk),
        .we    (ring_we),
        .waddr (slot_reg),
        .wdata ({bits_reg, zeros_reg}),
        .raddr (slot_reg),
        .rdata (ring_q)
    );

    swls_ram #(.WIDTH(CNT_W), .DEPTH(LEN_MAX + 1)) u_hist (
        .aclk  (aclk),
        .we    (hist_we),
        .waddr (haddr_reg),
        .wdata (hist_wdata),
        .raddr (in_haddr),
        .rdata (hist_q)
    );

    swls_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .stat    (div_stat),
        .quot    (div_quot)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (s_valid) state_next = ST_READ;
            ST_READ:      state_next = ST_DIV_ISSUE;
            ST_DIV_ISSUE: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_stat.done) begin
                    state_next = (op_reg == OP_BPCT) ? ST_DONE : ST_DIV_ISSUE;
                end
            end
            ST_DONE:      if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            ST_IDLE:      s_ready = 1'b1;
            ST_DIV_ISSUE: div_start = 1'b1;
            ST_DONE:      load_out = !m_valid_reg || m_ready;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        case (op_reg)
            OP_WAVG: begin
                div_num = NUM_W'(wbit_reg);
                div_den = DEN_W'(fill_reg);
            end
            OP_WZPCT: begin
                div_num = NUM_W'(wzero_reg) * NUM_W'(PCT_SCALE);
                div_den = DEN_W'(wbit_reg);
            end
            OP_OAVG: begin
                div_num = NUM_W'(obit_reg);
                div_den = DEN_W'(ack_reg);
            end
            OP_OZPCT: begin
                div_num = NUM_W'(ozero_reg) * NUM_W'(PCT_SCALE);
                div_den = DEN_W'(obit_reg);
            end
            OP_BPCT: begin
                if (have_bin_reg) begin
                    div_num = NUM_W'(bcount_reg) * NUM_W'(TENTHS_SCALE) + NUM_W'(ack_reg);
                    div_den = DEN_W'({ack_reg, 1'b0});
                end else begin
                    div_num = '0;
                    div_den = '0;
                end
            end
            default: begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    always_comb begin
        op_next       = op_reg;
        req_type_next = req_type_reg;
        bits_next     = bits_reg;
        zeros_next    = zeros_reg;
        haddr_next    = haddr_reg;
        bad_next      = bad_reg;
        slot_next     = slot_reg;
        fill_next     = fill_reg;
        wbit_next     = wbit_reg;
        wzero_next    = wzero_reg;
        obit_next     = obit_reg;
        ozero_next    = ozero_reg;
        ack_next      = ack_reg;
        hvalid_next   = hvalid_reg;
        bcount_next   = bcount_reg;
        have_bin_next = have_bin_reg;
        wavg_next     = wavg_reg;
        wzpct_next    = wzpct_reg;
        oavg_next     = oavg_reg;
        ozpct_next    = ozpct_reg;
        bpct_next     = bpct_reg;
        ring_we       = 1'b0;
        hist_we       = 1'b0;
        hist_wdata    = hist_val + 1'b1;

        if (s_accept) begin
            req_type_next = s_req_type;
            bits_next     = LEN_W'(s_ack_bits);
            zeros_next    = LEN_W'(s_ack_zeros);
            haddr_next    = in_haddr;
            bad_next      = in_bad;
        end

        if (state_reg == ST_READ) begin
            op_next       = OP_WAVG;
            have_bin_next = !bad_reg;
            bcount_next   = '0;
            if (!bad_reg && req_type_reg == REQ_RECORD) begin
                ring_we = 1'b1;
                if (32'(fill_reg) >= RING_DEPTH) begin
                    wbit_next  = wbit_reg - WSUM_W'(old_bits) + WSUM_W'(bits_reg);
                    wzero_next = wzero_reg - WSUM_W'(old_zeros) + WSUM_W'(zeros_reg);
                end else begin
                    fill_next  = fill_reg + 1'b1;
                    wbit_next  = wbit_reg + WSUM_W'(bits_reg);
                    wzero_next = wzero_reg + WSUM_W'(zeros_reg);
                end
                slot_next = (32'(slot_reg) == RING_DEPTH - 1) ? '0 : slot_reg + 1'b1;
                if (ack_reg != CNT_MAX) begin
                    ack_next   = ack_reg + 1'b1;
                    obit_next  = obit_reg + OSUM_W'(bits_reg);
                    ozero_next = ozero_reg + OSUM_W'(zeros_reg);
                    hist_we    = 1'b1;
                    hvalid_next[haddr_reg] = 1'b1;
                    bcount_next = hist_wdata;
                end else begin
                    bcount_next = hist_val;
                end
            end else if (!bad_reg) begin
                bcount_next = hist_val;
            end
        end

        if (state_reg == ST_DIV_WAIT && div_stat.done) begin
            case (op_reg)
                OP_WAVG:  wavg_next  = div_quot[6:0];
                OP_WZPCT: wzpct_next = div_quot[6:0];
                OP_OAVG:  oavg_next  = div_quot[6:0];
                OP_OZPCT: ozpct_next = div_quot[6:0];
                OP_BPCT:  bpct_next  = div_quot[9:0];
                default:  bpct_next  = bpct_reg;
            endcase
            if (op_reg != OP_BPCT) begin
                op_next = op_t'(op_reg + 3'd1);
            end
        end

        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_WAVG;
            slot_reg    <= '0;
            fill_reg    <= '0;
            wbit_reg    <= '0;
            wzero_reg   <= '0;
            obit_reg    <= '0;
            ozero_reg   <= '0;
            ack_reg     <= '0;
            hvalid_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            slot_reg    <= slot_next;
            fill_reg    <= fill_next;
            wbit_reg    <= wbit_next;
            wzero_reg   <= wzero_next;
            obit_reg    <= obit_next;
            ozero_reg   <= ozero_next;
            ack_reg     <= ack_next;
            hvalid_reg  <= hvalid_next;
            m_valid_reg <= m_valid_next;
        end
        req_type_reg <= req_type_next;
        bits_reg     <= bits_next;
        zeros_reg    <= zeros_next;
        haddr_reg    <= haddr_next;
        bad_reg      <= bad_next;
        bcount_reg   <= bcount_next;
        have_bin_reg <= have_bin_next;
        wavg_reg     <= wavg_next;
        wzpct_reg    <= wzpct_next;
        oavg_reg     <= oavg_next;
        ozpct_reg    <= ozpct_next;
        bpct_reg     <= bpct_next;
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_status           <= bad_reg;
            m_window_count     <= 5'(fill_reg);
            m_window_avg_len   <= wavg_reg;
            m_window_zero_pct  <= wzpct_reg;
            m_overall_avg_len  <= oavg_reg;
            m_overall_zero_pct <= ozpct_reg;
            m_ack_total        <= ack_reg;
            m_bin_count        <= bcount_reg;
            m_bin_pct_tenths   <= bpct_reg;
        end
    end

    assign m_valid = m_valid_reg;

    a_accept_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == ST_READ)
        else $error("accepted request did not move to the read state");

    a_hist_we_read: assert property (@(posedge aclk) disable iff (!aresetn)
        hist_we |-> state_reg == ST_READ)
        else $error("histogram written outside the read-modify-write cycle");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(fill_reg) <= RING_DEPTH)
        else $error("window fill level exceeds the window size");

    a_div_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_load_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !load_out)
        else $error("pending result overwritten before its transfer");

endmodule

/* sv/swls_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module swls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/swls_div.sv */
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Depends on swls_pkg for the status struct. A zero divisor gives a zero quotient.
module swls_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 40
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [NUM_W-1:0]      num,
    input  logic [DEN_W-1:0]      den,
    output swls_pkg::div_stat_t   stat,
    output logic [NUM_W-1:0]      quot
);
    import swls_pkg::*;

    localparam int CW = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    assign trial = {rem_reg, q_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            if (den == '0) begin
                q_next    = '0;
                done_next = 1'b1;
            end else begin
                rem_next  = '0;
                q_next    = num;
                den_next  = den;
                cnt_next  = CW'(NUM_W);
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            if (!diff[DEN_W]) begin
                rem_next = diff[DEN_W-1:0];
                q_next   = {q_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DEN_W-1:0];
                q_next   = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = q_reg;

endmodule

/* tb/testbench.sv */
// Testbench for the sliding window ack length statistics block.
// Drives record and read requests, predicts every result and checks each transfer.
// Depends on swls_pkg and sliding_window_length_stats_top.
`timescale 1ns / 1ps

module testbench;
    import swls_pkg::*;

    localparam int WIN = RING_DEPTH;
    localparam int MAXB = LEN_MAX;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        bit        status;
        bit [4:0]  window_count;
        bit [6:0]  window_avg_len;
        bit [6:0]  window_zero_pct;
        bit [6:0]  overall_avg_len;
        bit [6:0]  overall_zero_pct;
        bit [31:0] ack_total;
        bit [31:0] bin_count;
        bit [9:0]  bin_pct_tenths;
    } stats_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_req_type = REQ_RECORD;
    logic [6:0]  s_ack_bits = '0;
    logic [6:0]  s_ack_zeros = '0;
    logic [6:0]  s_bin_index = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_status;
    logic [4:0]  m_window_count;
    logic [6:0]  m_window_avg_len;
    logic [6:0]  m_window_zero_pct;
    logic [6:0]  m_overall_avg_len;
    logic [6:0]  m_overall_zero_pct;
    logic [31:0] m_ack_total;
    logic [31:0] m_bin_count;
    logic [9:0]  m_bin_pct_tenths;

    stats_t      expected_stats[$];
    int          error_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          recv_hold = 0;
    int          quiet_cycles = 0;

    bit [6:0]    ring_len[WIN];
    bit [6:0]    ring_zero[WIN];
    int          slot_ptr = 0;
    int          fill = 0;
    bit [63:0]   win_bits = 0;
    bit [63:0]   win_zeros = 0;
    bit [63:0]   all_bits = 0;
    bit [63:0]   all_zeros = 0;
    bit [31:0]   acks = 0;
    bit [31:0]   hist[MAXB+1];

    sliding_window_length_stats_top i_dut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic bit [63:0] quot(bit [63:0] num, bit [63:0] den);
        return den == 0 ? 64'd0 : num / den;
    endfunction

    function automatic stats_t predict_stats(bit req, bit [6:0] len, bit [6:0] zeros,
                                             bit [6:0] idx);
        stats_t r;
        bit [31:0] cnt = 0;
        bit have_bin = 0;
        r.status = 1'b0;
        if (req == REQ_RECORD) begin
            if (len == 0 || len > MAXB || zeros > len) begin
                r.status = 1'b1;
            end else begin
                if (fill >= WIN) begin
                    win_bits -= ring_len[slot_ptr];
                    win_zeros -= ring_zero[slot_ptr];
                end else begin
                    fill++;
                end
                ring_len[slot_ptr] = len;
                ring_zero[slot_ptr] = zeros;
                win_bits += len;
                win_zeros += zeros;
                slot_ptr = (slot_ptr + 1) % WIN;
                if (acks != CNT_MAX) begin
                    acks++;
                    all_bits += len;
                    all_zeros += zeros;
                    hist[len]++;
                end
                cnt = hist[len];
                have_bin = 1;
            end
        end else if (idx > MAXB) begin
            r.status = 1'b1;
        end else begin
            cnt = hist[idx];
            have_bin = 1;
        end
        r.window_count = 5'(fill);
        r.window_avg_len = 7'(quot(win_bits, 64'(fill)));
        r.window_zero_pct = 7'(quot(win_zeros * PCT_SCALE, win_bits));
        r.overall_avg_len = 7'(quot(all_bits, 64'(acks)));
        r.overall_zero_pct = 7'(quot(all_zeros * PCT_SCALE, all_bits));
        r.ack_total = acks;
        r.bin_count = have_bin ? cnt : 32'd0;
        r.bin_pct_tenths = (have_bin && acks != 0) ?
            10'((64'(cnt) * TENTHS_SCALE + acks) / (64'(acks) * 2)) : 10'd0;
        return r;
    endfunction

    // Called at a falling edge; returns at a falling edge with valid still high
    // unless the sender chose to idle.
    task automatic send_request(bit req, bit [6:0] len, bit [6:0] zeros, bit [6:0] idx);
        s_valid <= 1'b1;
        s_req_type <= req;
        s_ack_bits <= len;
        s_ack_zeros <= zeros;
        s_bin_index <= idx;
        do @(posedge aclk); while (!s_ready);
        expected_stats.push_back(predict_stats(req, len, zeros, idx));
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
    endtask

    task automatic send_random_request();
        int kind = $urandom_range(99);
        bit [6:0] len;
        if (kind < 60) begin
            len = 7'($urandom_range(MAXB, 1));
            send_request(REQ_RECORD, len, 7'($urandom_range(len, 0)), 7'($urandom));
        end else if (kind < 70) begin
            send_request(REQ_RECORD, 7'($urandom), 7'($urandom), 7'($urandom));
        end else if (kind < 92) begin
            send_request(REQ_READ, 7'($urandom), 7'($urandom), 7'($urandom_range(MAXB, 0)));
        end else begin
            send_request(REQ_READ, 7'($urandom), 7'($urandom),
                         7'($urandom_range(127, MAXB + 1)));
        end
    endtask

    task automatic wait_drained();
        while (expected_stats.size() != 0) @(negedge aclk);
    endtask

    task automatic test_edge_cases();
        send_request(REQ_READ, 0, 0, 0);
        send_request(REQ_READ, 0, 0, MAXB);
        send_request(REQ_READ, 0, 0, MAXB + 1);
        send_request(REQ_READ, 7'h7f, 7'h7f, 7'h7f);
        send_request(REQ_RECORD, 0, 0, 0);
        send_request(REQ_RECORD, MAXB + 1, 0, 0);
        send_request(REQ_RECORD, 7'h7f, 7'h7f, 0);
        send_request(REQ_RECORD, 5, 6, 0);
        send_request(REQ_RECORD, 1, 0, 0);
        send_request(REQ_RECORD, 1, 1, 0);
        send_request(REQ_RECORD, MAXB, MAXB, 0);
        send_request(REQ_RECORD, MAXB, 0, 0);
        send_request(REQ_RECORD, 37, 19, 0);
        send_request(REQ_READ, 0, 0, 1);
        send_request(REQ_READ, 0, 0, MAXB);
        send_request(REQ_READ, 0, 0, 2);
        send_request(REQ_READ, 0, 0, 0);
        send_request(REQ_READ, 0, 0, 37);
    endtask

    task automatic test_window_wrap();
        for (int i = 0; i < 2 * WIN + 3; i++)
            send_request(REQ_RECORD, 7'((i * 7) % MAXB + 1), 7'(i % 5), 0);
        send_request(REQ_READ, 0, 0, 8);
    endtask

    task automatic test_backpressure();
        recv_hold = 3000;
        for (int i = 0; i < 20; i++)
            send_random_request();
    endtask

    task automatic test_random(int count, int tx_idle, int rx_idle);
        send_idle_pct = tx_idle;
        recv_idle_pct = rx_idle;
        for (int i = 0; i < count; i++)
            send_random_request();
    endtask

    always @(negedge aclk) begin
        if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= $urandom_range(99) >= recv_idle_pct;
        end
    end

    task automatic check_field(string name, longint unsigned exp, longint unsigned act);
        if (exp != act) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
        end
    endtask

    always @(posedge aclk) begin
        stats_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_stats.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result transfer, expected none, actual status %0d",
                         $time, m_status);
            end else begin
                e = expected_stats.pop_front();
                check_field("status", e.status, m_status);
                check_field("window_count", e.window_count, m_window_count);
                check_field("window_avg_len", e.window_avg_len, m_window_avg_len);
                check_field("window_zero_pct", e.window_zero_pct, m_window_zero_pct);
                check_field("overall_avg_len", e.overall_avg_len, m_overall_avg_len);
                check_field("overall_zero_pct", e.overall_zero_pct, m_overall_zero_pct);
                check_field("ack_total", e.ack_total, m_ack_total);
                check_field("bin_count", e.bin_count, m_bin_count);
                check_field("bin_pct_tenths", e.bin_pct_tenths, m_bin_pct_tenths);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (s_valid || expected_stats.size() != 0) begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        foreach (hist[i]) hist[i] = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_edge_cases();
        test_window_wrap();
        test_backpressure();
        test_random(415, 8, 71);
        test_random(415, 71, 8);
        test_random(415, 0, 0);
        s_valid <= 1'b0;
        wait_drained();
        repeat (300) @(negedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* sliding_window_length_stats_top.f */
sv/swls_pkg.sv
sv/swls_ram.sv
sv/swls_div.sv
sv/sliding_window_length_stats_top.sv
tb/testbench.sv
